/* src/tks_pkg.sv */
`timescale 1ns / 1ps

package tks_pkg;

  localparam int SCORE_W      = 16;
  localparam int CLASS_W      = 12;
  localparam int RANK_W       = 3;
  localparam int COUNT_W      = 3;
  localparam int RESULT_LIMIT = 5;

  localparam logic [COUNT_W-1:0] TOP_COUNT_RESET = 3'd5;

  // One entry of the ranked list.
  typedef struct packed {
    logic               valid;
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] score;
  } tks_entry_t;

  // Control from the input stage to the ranked list.
  typedef struct packed {
    logic step;
    logic clear;
  } tks_step_t;

endpackage

/* src/tks_insert.sv */
`timescale 1ns / 1ps

module tks_insert import tks_pkg::*; #(
  parameter int TOP_MAX     = 5,
  parameter int MAX_CLASSES = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tks_step_t                 ctl,
  input  logic [SCORE_W-1:0]        score,
  output tks_entry_t [TOP_MAX-1:0]  snap,
  output logic                      snap_overflow
);

  localparam int IDX_W = $clog2(MAX_CLASSES + 1);
  localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(MAX_CLASSES);

  tks_entry_t [TOP_MAX-1:0] kept;
  logic [IDX_W-1:0]         next_index;
  logic                     overflow_seen;

  logic                     full;
  logic                     do_ins;
  tks_entry_t               new_e;
  logic [TOP_MAX-1:0]       take;
  tks_entry_t [TOP_MAX-1:0] ins;

  assign full   = (next_index == IDX_FULL);
  assign do_ins = !full && (score != '0);

  always_comb begin
    new_e.valid = 1'b1;
    new_e.cls   = CLASS_W'(next_index);
    new_e.score = score;
  end

  // The list is kept in descending order with valid entries packed at the
  // front, so the take vector is monotone: the first set bit is the slot of
  // the new score and every later slot shifts down by one.
  for (genvar g = 0; g < TOP_MAX; g++) begin : g_slot
    assign take[g] = !kept[g].valid || (score > kept[g].score);
    if (g == 0) begin : g_head
      assign ins[g] = (do_ins && take[g]) ? new_e : kept[g];
    end else begin : g_tail
      assign ins[g] = !(do_ins && take[g]) ? kept[g] :
                      (take[g-1] ? kept[g-1] : new_e);
    end
  end

  assign snap          = ins;
  assign snap_overflow = overflow_seen | full;

  always_ff @(posedge clk) begin
    if (rst) begin
      kept          <= '0;
      next_index    <= '0;
      overflow_seen <= 1'b0;
    end else if (ctl.step) begin
      if (ctl.clear) begin
        kept          <= '0;
        next_index    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        kept          <= ins;
        overflow_seen <= overflow_seen | full;
        if (!full) begin
          next_index <= next_index + 1'b1;
        end
      end
    end
  end

endmodule

/* src/tks_report.sv */
`timescale 1ns / 1ps

module tks_report import tks_pkg::*; #(
  parameter int TOP_MAX = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  tks_entry_t [TOP_MAX-1:0] snap,
  input  logic                     snap_overflow,
  input  logic [((((TOP_MAX < RESULT_LIMIT) ? TOP_MAX : RESULT_LIMIT) > 1) ?
                $clog2((TOP_MAX < RESULT_LIMIT) ? TOP_MAX : RESULT_LIMIT) : 1)-1:0]
                                   last_idx,
  input  logic                     result_stall,
  output logic                     result_valid,
  output logic [RANK_W-1:0]        rank,
  output logic [CLASS_W-1:0]       class_index,
  output logic [SCORE_W-1:0]       best_score,
  output logic                     slot_valid,
  output logic                     count_overflow,
  output logic                     last_rank,
  output logic                     free
);

  localparam int LIMIT = (TOP_MAX < RESULT_LIMIT) ? TOP_MAX : RESULT_LIMIT;
  localparam int PTR_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;

  tks_entry_t       bank [LIMIT];
  logic             busy;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] stop;
  logic             overflow;

  tks_entry_t cur;
  logic       taken;

  assign cur   = bank[ptr];
  assign taken = busy && !result_stall;

  assign result_valid   = busy;
  assign rank           = RANK_W'(ptr);
  assign class_index    = cur.valid ? cur.cls : '0;
  assign best_score     = cur.valid ? cur.score : '0;
  assign slot_valid     = cur.valid;
  assign count_overflow = overflow;
  assign last_rank      = (ptr == stop);
  assign free           = !busy || (taken && last_rank);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < LIMIT; i++) begin
        bank[i] <= snap[i];
      end
      stop     <= last_idx;
      overflow <= snap_overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ptr  <= '0;
    end else begin
      priority if (load) begin
        busy <= 1'b1;
        ptr  <= '0;
      end else if (taken) begin
        if (last_rank) begin
          busy <= 1'b0;
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
    end
  end

endmodule

/* src/top_k_score_selector.sv */
`timescale 1ns / 1ps

// Streaming top-k selector. Class scores (unsigned Q0.16) arrive one request
// per cycle, unless score_stall holds them, in class order; the position in
// the stream is the class index. The block keeps the TOP_MAX best positive
// scores, ties going to the earlier class, and on the request marked
// final_class it reports the best top_count ranks (top_count 0 reads as 1,
// values above min(TOP_MAX, 5) are clamped) as one result request per rank,
// best first, with last_rank on the final one. A score enters the ranked
// list when the input register that accepted it moves on. A final score is
// taken into the list snapshot that the report buffer loads as the score
// leaves the input register, and the buffer then offers its ranks in turn.
// Scores keep streaming in at one per cycle while a report drains: the list
// is copied into a report buffer and cleared in the same cycle. A second
// final score waits in the input register until the previous report has
// delivered its last rank, so the report buffer's single drain port sets
// the rate of back-to-back sets. Ranks with no positive score show
// slot_valid 0 with zero index and score. After MAX_CLASSES scores further
// scores are ignored and every result of that set carries count_overflow.
module top_k_score_selector import tks_pkg::*; #(
  parameter int TOP_MAX     = 5,
  parameter int MAX_CLASSES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel: top_count.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  // Score channel.
  input  logic               score_valid,
  output logic               score_stall,
  input  logic [SCORE_W-1:0] class_score,
  input  logic               final_class,
  // Result channel.
  output logic               result_valid,
  input  logic               result_stall,
  output logic [RANK_W-1:0]  rank,
  output logic [CLASS_W-1:0] class_index,
  output logic [SCORE_W-1:0] best_score,
  output logic               slot_valid,
  output logic               count_overflow,
  output logic               last_rank
);

  localparam int LIMIT = (TOP_MAX < RESULT_LIMIT) ? TOP_MAX : RESULT_LIMIT;
  localparam int PTR_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;

  // The top_count register. Writes are always taken at once.
  logic [COUNT_W-1:0] top_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= TOP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      top_count <= cfg_data;
    end
  end

  // Input register. It moves on every cycle unless it holds a final score
  // and the report buffer is still delivering the previous set.
  logic               in_full;
  logic [SCORE_W-1:0] in_score;
  logic               in_final;
  logic               in_take;
  logic               advance;
  logic               report_free;

  assign advance     = in_full && (!in_final || report_free);
  assign score_stall = in_full && !advance;
  assign in_take     = score_valid && !score_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_take || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_score <= class_score;
      in_final <= final_class;
    end
  end

  // Ranked list with parallel compare-and-insert.
  tks_step_t                ctl;
  tks_entry_t [TOP_MAX-1:0] snap;
  logic                     snap_overflow;

  assign ctl.step  = advance;
  assign ctl.clear = in_final;

  tks_insert #(
    .TOP_MAX     (TOP_MAX),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_insert (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .score         (in_score),
    .snap          (snap),
    .snap_overflow (snap_overflow)
  );

  // Number of ranks to report, held as the index of the last one.
  logic [COUNT_W-1:0] count;
  logic [PTR_W-1:0]   last_idx;

  always_comb begin
    count = top_count;
    priority if (top_count == '0) begin
      count = COUNT_W'(1);
    end else if (top_count > COUNT_W'(LIMIT)) begin
      count = COUNT_W'(LIMIT);
    end
    last_idx = PTR_W'(count - COUNT_W'(1));
  end

  tks_report #(
    .TOP_MAX (TOP_MAX)
  ) u_report (
    .clk            (clk),
    .rst            (rst),
    .load           (advance && in_final),
    .snap           (snap),
    .snap_overflow  (snap_overflow),
    .last_idx       (last_idx),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .rank           (rank),
    .class_index    (class_index),
    .best_score     (best_score),
    .slot_valid     (slot_valid),
    .count_overflow (count_overflow),
    .last_rank      (last_rank),
    .free           (report_free)
  );

  // Within a report the ranks count up by one.
  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !last_rank) |=>
      (result_valid && rank == $past(rank) + 3'd1))
    else $error("rank did not advance by one inside a report");

  // Once a rank is empty, every later rank of the same report is empty.
  a_empty_tail: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !last_rank && !slot_valid) |=> !slot_valid)
    else $error("filled rank after an empty rank");

  // Filled ranks come out in non-increasing score order.
  a_score_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !last_rank && slot_valid) |=>
      (!slot_valid || best_score <= $past(best_score)))
    else $error("ranked scores out of order");

  // The overflow flag is constant across one report.
  a_overflow_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !last_rank) |=>
      (count_overflow == $past(count_overflow)))
    else $error("count_overflow changed inside a report");

endmodule
